/* rtl/core/assert_macros.svh */
// assertion macros shared by the console writer rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication form of the above
`define ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

/* rtl/core/tcw_pkg.sv */
// package for the text console writer: sizes, character codes, item types
// no dependencies; used by every rtl module and interface of the block
package tcw_pkg;

   localparam int MaxColumns = 80;
   localparam int MaxRows    = 25;
   localparam int TabStop    = 8;
   localparam int CellCount  = MaxColumns * MaxRows;
   localparam int AddrW      = $clog2(CellCount + 1);
   localparam int RowW       = 5;
   localparam int ColW       = 7;
   localparam int TabCntW    = $clog2(TabStop + 1);
   localparam int QDepth     = 2;
   localparam int QPtrW      = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCntW      = $clog2(QDepth + 1);

   // character codes
   localparam logic [7:0] ChNewline   = 8'h0A;
   localparam logic [7:0] ChReturn    = 8'h0D;
   localparam logic [7:0] ChBackspace = 8'h08;
   localparam logic [7:0] ChTab       = 8'h09;
   localparam logic [7:0] ChEscape    = 8'h1B;
   localparam logic [7:0] ChCaret     = 8'h5E;
   localparam logic [7:0] ChBracket   = 8'h5B;
   localparam logic [7:0] ChSpace     = 8'h20;

   // reset contents of the screen and register reset values
   localparam logic [15:0] ResetCell   = 16'h0720;
   localparam logic [7:0]  AttrReset   = 8'd7;
   localparam logic [6:0]  ColsReset   = 7'd80;
   localparam logic [4:0]  RowsReset   = 5'd25;

   // register index codes
   localparam logic [1:0] RegAttr = 2'd0;
   localparam logic [1:0] RegCols = 2'd1;
   localparam logic [1:0] RegRows = 2'd2;

   typedef enum logic [1:0] {
      KIND_PUT   = 2'd0,
      KIND_READ  = 2'd1,
      KIND_SETC  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      OP_PLAIN   = 4'd0,
      OP_NEWLINE = 4'd1,
      OP_RETURN  = 4'd2,
      OP_BACK    = 4'd3,
      OP_TAB     = 4'd4,
      OP_ESCAPE  = 4'd5,
      OP_READ    = 4'd6,
      OP_SETCUR  = 4'd7,
      OP_CLEAR   = 4'd8
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [7:0]       char_code;
      logic [RowW-1:0]  row;
      logic [ColW-1:0]  column;
   } q_item_type;

   typedef struct packed {
      logic [7:0]       attr;
      logic [ColW-1:0]  cols;
      logic [RowW-1:0]  rows;
   } cfg_type;

endpackage

/* rtl/core/tcw_ifs.sv */
// valid/ready channel interfaces for the console writer request and response
// depends on tcw_pkg
interface tcw_req_if import tcw_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [1:0]      kind;
   logic [7:0]      char_code;
   logic [RowW-1:0] row;
   logic [ColW-1:0] column;

   modport source (output valid, kind, char_code, row, column, input ready);
   modport sink   (input valid, kind, char_code, row, column, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [RowW-1:0] cursor_row_now;
   logic [ColW-1:0] cursor_column_now;
   logic [7:0]      cell_char;
   logic [7:0]      cell_attribute;

   modport source (output valid, cursor_row_now, cursor_column_now, cell_char,
                   cell_attribute, input ready);
   modport sink   (input valid, cursor_row_now, cursor_column_now, cell_char,
                   cell_attribute, output ready);
endinterface

/* rtl/core/text_console_writer.sv */
// text console writer top: csr registers, front queue and back sequencer
// a response is loaded in ST_DONE once the output is free; a plain char runs ST_START, ST_ADDR,
// ST_WRITE and ST_NEXT, a read cell ST_START, ST_RREQ and ST_RDATA; each extra char write (tab
// space, escape bracket) repeats ST_ADDR, ST_WRITE and ST_NEXT, a scroll adds ST_SCRL and ST_SBLK,
// a clear ST_CLR; one item at a time, up to 2 more requests wait in the queue while busy
// sync active-high reset starts a screen fill; csr writes taken anytime
module text_console_writer import tcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tcw_req_if.sink     req,
   tcw_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type     cfg_ff, cfg_in;
   logic        head_valid;
   q_item_type  head_item;
   logic        head_pop;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   // csr write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (paddr[3:2])
            RegAttr: cfg_in.attr = pwdata[7:0];
            RegCols: cfg_in.cols = pwdata[ColW-1:0];
            RegRows: cfg_in.rows = pwdata[RowW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attr <= AttrReset;
         cfg_ff.cols <= ColsReset;
         cfg_ff.rows <= RowsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // csr read mux
   always_comb begin
      unique case (paddr[3:2])
         RegAttr: prdata = {24'd0, cfg_ff.attr};
         RegCols: prdata = {{(32-ColW){1'b0}}, cfg_ff.cols};
         RegRows: prdata = {{(32-RowW){1'b0}}, cfg_ff.rows};
         default: prdata = '0;
      endcase
   end

   tcw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   tcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp        (rsp)
   );

endmodule

/* rtl/core/tcw_front.sv */
// front end: accepts request transfers, classifies them and queues them
// depends on tcw_pkg, tcw_ifs and assert_macros.svh
`include "assert_macros.svh"

module tcw_front import tcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tcw_req_if.sink     req,
   output logic        head_valid,
   output q_item_type  head_item,
   input  logic        head_pop
);

   q_item_type         q_mem [QDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]   count_ff, count_in;
   q_item_type         new_item;
   logic               push;

   // classify the incoming item
   always_comb begin
      new_item.char_code = req.char_code;
      new_item.row       = req.row;
      new_item.column    = req.column;
      unique case (kind_type'(req.kind))
         KIND_PUT: begin
            unique case (req.char_code)
               ChNewline:   new_item.op = OP_NEWLINE;
               ChReturn:    new_item.op = OP_RETURN;
               ChBackspace: new_item.op = OP_BACK;
               ChTab:       new_item.op = OP_TAB;
               ChEscape:    new_item.op = OP_ESCAPE;
               default:     new_item.op = OP_PLAIN;
            endcase
         end
         KIND_READ:  new_item.op = OP_READ;
         KIND_SETC:  new_item.op = OP_SETCUR;
         default:    new_item.op = OP_CLEAR;
      endcase
   end

   assign req.ready  = (count_ff < QCntW'(QDepth));
   assign push       = req.valid && req.ready;
   assign head_valid = (count_ff != '0);
   assign head_item  = q_mem[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop && head_valid) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !(head_pop && head_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop && head_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= new_item;
      end
   end

   `ASSERT_CLK(a_q_bound, (count_ff <= QCntW'(QDepth)), "queue count above depth")

endmodule

/* rtl/core/tcw_back.sv */
// back end: screen memory, cursor and the sequencer that carries out items
// depends on tcw_pkg, tcw_ifs and assert_macros.svh
`include "assert_macros.svh"

module tcw_back import tcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        head_valid,
   input  q_item_type  head_item,
   output logic        head_pop,
   tcw_rsp_if.source   rsp
);

   typedef enum logic [11:0] {
      ST_INIT  = 12'b000000000001,
      ST_IDLE  = 12'b000000000010,
      ST_START = 12'b000000000100,
      ST_ADDR  = 12'b000000001000,
      ST_WRITE = 12'b000000010000,
      ST_NEXT  = 12'b000000100000,
      ST_SCRL  = 12'b000001000000,
      ST_SBLK  = 12'b000010000000,
      ST_RREQ  = 12'b000100000000,
      ST_RDATA = 12'b001000000000,
      ST_CLR   = 12'b010000000000,
      ST_DONE  = 12'b100000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [RowW-1:0]    row_ff, row_in;
   logic [ColW-1:0]    col_ff, col_in;
   logic [AddrW-1:0]   idx_ff, idx_in;
   logic [AddrW-1:0]   addr_ff, addr_in;
   logic [AddrW-1:0]   total_ff, total_in;
   logic [7:0]         pc_ff, pc_in;
   logic               tab_ff, tab_in;
   logic [TabCntW-1:0] n_ff, n_in;
   logic               esc_ff, esc_in;
   q_item_type         item_ff, item_in;
   logic [15:0]        cell_ff, cell_in;
   logic               sh_valid_ff, sh_valid_in;
   logic [AddrW-1:0]   sh_dst_ff, sh_dst_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RowW-1:0]    rsp_row_ff;
   logic [ColW-1:0]    rsp_col_ff;
   logic [15:0]        rsp_cell_ff;
   logic               rsp_load;

   logic [15:0]        mem [CellCount];
   logic [15:0]        rd_data_ff;
   logic [AddrW-1:0]   rd_addr;
   logic               we;
   logic [AddrW-1:0]   wa;
   logic [15:0]        wd;

   logic [ColW-1:0]    w_eff;
   logic [RowW-1:0]    h_eff;
   logic [RowW-1:0]    cr_cl, r_cl;
   logic [ColW-1:0]    cc_cl, c_cl;
   logic [15:0]        blank;

   // effective screen size and clamped positions
   always_comb begin
      if (cfg.cols == '0) w_eff = ColW'(1);
      else if (cfg.cols > ColW'(MaxColumns)) w_eff = ColW'(MaxColumns);
      else w_eff = cfg.cols;
      if (cfg.rows == '0) h_eff = RowW'(1);
      else if (cfg.rows > RowW'(MaxRows)) h_eff = RowW'(MaxRows);
      else h_eff = cfg.rows;
      cr_cl = (row_ff > h_eff - 1'b1) ? h_eff - 1'b1 : row_ff;
      cc_cl = (col_ff > w_eff - 1'b1) ? w_eff - 1'b1 : col_ff;
      r_cl  = (item_ff.row > h_eff - 1'b1) ? h_eff - 1'b1 : item_ff.row;
      c_cl  = (item_ff.column > w_eff - 1'b1) ? w_eff - 1'b1 : item_ff.column;
      blank = {cfg.attr, ChSpace};
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign rd_addr  = (state_ff == ST_RREQ) ? addr_ff : idx_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      idx_in      = idx_ff;
      addr_in     = addr_ff;
      total_in    = total_ff;
      pc_in       = pc_ff;
      tab_in      = tab_ff;
      n_in        = n_ff;
      esc_in      = esc_ff;
      item_in     = item_ff;
      cell_in     = cell_ff;
      sh_valid_in = 1'b0;
      sh_dst_in   = sh_dst_ff;
      head_pop    = 1'b0;
      we          = 1'b0;
      wa          = idx_ff;
      wd          = blank;
      unique case (state_ff)
         ST_INIT: begin
            we = 1'b1;
            wd = ResetCell;
            if (idx_ff == AddrW'(CellCount - 1)) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               item_in  = head_item;
               state_in = ST_START;
            end
         end
         ST_START: begin
            row_in   = cr_cl;
            col_in   = cc_cl;
            cell_in  = '0;
            total_in = AddrW'(h_eff * w_eff);
            unique case (item_ff.op)
               OP_PLAIN: begin
                  pc_in    = item_ff.char_code;
                  state_in = ST_ADDR;
               end
               OP_NEWLINE: begin
                  col_in = '0;
                  if (RowW'(cr_cl + 1'b1) == h_eff) begin
                     row_in   = h_eff - 1'b1;
                     idx_in   = AddrW'(w_eff);
                     state_in = ST_SCRL;
                  end else begin
                     row_in   = cr_cl + 1'b1;
                     state_in = ST_DONE;
                  end
               end
               OP_RETURN: begin
                  col_in   = '0;
                  state_in = ST_DONE;
               end
               OP_BACK: begin
                  if (cc_cl == '0) begin
                     if (cr_cl != '0) begin
                        row_in = cr_cl - 1'b1;
                        col_in = w_eff - 1'b1;
                     end
                  end else begin
                     col_in = cc_cl - 1'b1;
                  end
                  state_in = ST_DONE;
               end
               OP_TAB: begin
                  tab_in   = 1'b1;
                  n_in     = '0;
                  state_in = ST_NEXT;
               end
               OP_ESCAPE: begin
                  pc_in    = ChCaret;
                  esc_in   = 1'b1;
                  state_in = ST_ADDR;
               end
               OP_READ: begin
                  addr_in  = AddrW'(r_cl * w_eff) + AddrW'(c_cl);
                  state_in = ST_RREQ;
               end
               OP_SETCUR: begin
                  row_in   = r_cl;
                  col_in   = c_cl;
                  state_in = ST_DONE;
               end
               default: begin
                  idx_in   = '0;
                  state_in = ST_CLR;
               end
            endcase
         end
         ST_ADDR: begin
            addr_in  = AddrW'(row_ff * w_eff) + AddrW'(col_ff);
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            we = 1'b1;
            wa = addr_ff;
            wd = {cfg.attr, pc_ff};
            if (ColW'(col_ff + 1'b1) == w_eff) begin
               col_in = '0;
               if (RowW'(row_ff + 1'b1) == h_eff) begin
                  row_in   = h_eff - 1'b1;
                  idx_in   = AddrW'(w_eff);
                  state_in = ST_SCRL;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = ST_NEXT;
               end
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (tab_ff && (n_ff < TabCntW'(TabStop)) &&
                ((col_ff % ColW'(TabStop)) != '0)) begin
               pc_in    = ChSpace;
               n_in     = n_ff + 1'b1;
               state_in = ST_ADDR;
            end else if (esc_ff) begin
               pc_in    = ChBracket;
               esc_in   = 1'b0;
               state_in = ST_ADDR;
            end else begin
               tab_in   = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_SCRL: begin
            // move each cell one row up, one read and one write a cycle
            if (idx_ff < total_ff) begin
               sh_valid_in = 1'b1;
               sh_dst_in   = idx_ff - AddrW'(w_eff);
               idx_in      = idx_ff + 1'b1;
            end
            if (sh_valid_ff) begin
               we = 1'b1;
               wa = sh_dst_ff;
               wd = rd_data_ff;
            end
            if ((idx_ff >= total_ff) && !sh_valid_ff) begin
               idx_in   = total_ff - AddrW'(w_eff);
               state_in = ST_SBLK;
            end
         end
         ST_SBLK: begin
            we = 1'b1;
            if (idx_ff == total_ff - 1'b1) begin
               state_in = ST_NEXT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RREQ: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            cell_in  = rd_data_ff;
            state_in = ST_DONE;
         end
         ST_CLR: begin
            we = 1'b1;
            if (idx_ff == total_ff - 1'b1) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp.ready) || rsp_load;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         idx_ff       <= '0;
         tab_ff       <= 1'b0;
         esc_ff       <= 1'b0;
         sh_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         idx_ff       <= idx_in;
         tab_ff       <= tab_in;
         esc_ff       <= esc_in;
         sh_valid_ff  <= sh_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      total_ff  <= total_in;
      pc_ff     <= pc_in;
      n_ff      <= n_in;
      item_ff   <= item_in;
      cell_ff   <= cell_in;
      sh_dst_ff <= sh_dst_in;
      if (rsp_load) begin
         rsp_row_ff  <= row_ff;
         rsp_col_ff  <= col_ff;
         rsp_cell_ff <= cell_ff;
      end
   end

   // screen memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.cursor_row_now    = rsp_row_ff;
   assign rsp.cursor_column_now = rsp_col_ff;
   assign rsp.cell_char         = rsp_cell_ff[7:0];
   assign rsp.cell_attribute    = rsp_cell_ff[15:8];

   `ASSERT_IMPL(a_wr_in_screen, (state_ff == ST_WRITE), (addr_ff < total_ff), "write outside screen")
   `ASSERT_IMPL(a_shift_dst, sh_valid_ff, (sh_dst_ff < total_ff), "scroll target outside screen")
   `ASSERT_IMPL(a_no_pop_busy, head_pop, ($past(state_ff) != ST_START), "pop while busy")

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for the text console writer: directed and random items
// depends on tcw_pkg, tcw_ifs and text_console_writer from the rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam int          CycleLimit = 10000000;
   localparam int          DrainWait  = 4000;
   localparam logic [3:0]  AddrAttr   = {RegAttr, 2'b00};
   localparam logic [3:0]  AddrCols   = {RegCols, 2'b00};
   localparam logic [3:0]  AddrRows   = {RegRows, 2'b00};

   typedef struct {
      logic [RowW-1:0] cur_row;
      logic [ColW-1:0] cur_col;
      logic [7:0]      ch;
      logic [7:0]      attr;
   } console_view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_writer dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus.sink),
      .rsp     (rsp_bus.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow screen, cursor and settings
   logic [15:0]     shadow_cells [CellCount];
   int unsigned     cur_r, cur_c;
   logic [7:0]      attr_q;
   logic [ColW-1:0] cols_q;
   logic [RowW-1:0] rows_q;

   console_view_type pending_views [$];
   int          err_count = 0;
   int          cycles = 0;
   bit          req_steady = 0;
   bit          rsp_steady = 0;

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      err_count++;
   endtask

   function automatic int unsigned width_now();
      if (cols_q == 0) return 1;
      if (cols_q > MaxColumns) return MaxColumns;
      return cols_q;
   endfunction

   function automatic int unsigned height_now();
      if (rows_q == 0) return 1;
      if (rows_q > MaxRows) return MaxRows;
      return rows_q;
   endfunction

   function automatic void store_cell(int unsigned x, int unsigned y, logic [7:0] ch,
                                      logic [7:0] at);
      int unsigned idx;
      idx = y * width_now() + x;
      if (idx < CellCount) shadow_cells[idx] = {at, ch};
   endfunction

   function automatic logic [15:0] fetch_cell(int unsigned x, int unsigned y);
      int unsigned idx;
      idx = y * width_now() + x;
      if (idx < CellCount) return shadow_cells[idx];
      return 16'h0000;
   endfunction

   // shift rows up, blank the last row
   function automatic void scroll_screen();
      int unsigned w, h;
      logic [15:0] v;
      w = width_now();
      h = height_now();
      for (int unsigned y = 1; y < h; y++)
         for (int unsigned x = 0; x < w; x++) begin
            v = fetch_cell(x, y);
            store_cell(x, y - 1, v[7:0], v[15:8]);
         end
      for (int unsigned x = 0; x < w; x++) store_cell(x, h - 1, ChSpace, attr_q);
      if (cur_r > 0) cur_r--;
   endfunction

   function automatic void emit_char(logic [7:0] ch);
      store_cell(cur_c, cur_r, ch, attr_q);
      cur_c++;
      if (cur_c == width_now()) begin
         cur_c = 0;
         cur_r++;
         if (cur_r == height_now()) scroll_screen();
      end
   endfunction

   function automatic void write_char(logic [7:0] ch);
      case (ch)
         ChNewline: begin
            cur_r++;
            if (cur_r == height_now()) scroll_screen();
            cur_c = 0;
         end
         ChReturn: cur_c = 0;
         ChBackspace: begin
            if (cur_c == 0) begin
               if (cur_r != 0) begin
                  cur_r--;
                  cur_c = width_now() - 1;
               end
            end else cur_c--;
         end
         ChTab: begin
            for (int n = 0; n < TabStop && (cur_c % TabStop) != 0; n++) emit_char(ChSpace);
         end
         ChEscape: begin
            emit_char(ChCaret);
            emit_char(ChBracket);
         end
         default: emit_char(ch);
      endcase
   endfunction

   // effect of one transfer on the shadow console, and the view it returns
   function automatic console_view_type console_step(kind_type kind, logic [7:0] ch,
                                                logic [RowW-1:0] row, logic [ColW-1:0] col);
      console_view_type v;
      int unsigned w, h, r, c;
      logic [15:0] rd_word;
      w = width_now();
      h = height_now();
      r = row;
      c = col;
      v.ch = 8'h00;
      v.attr = 8'h00;
      if (cur_r > h - 1) cur_r = h - 1;
      if (cur_c > w - 1) cur_c = w - 1;
      if (r > h - 1) r = h - 1;
      if (c > w - 1) c = w - 1;
      case (kind)
         KIND_PUT: write_char(ch);
         KIND_READ: begin
            rd_word = fetch_cell(c, r);
            v.ch = rd_word[7:0];
            v.attr = rd_word[15:8];
         end
         KIND_SETC: begin
            cur_r = r;
            cur_c = c;
         end
         default: begin
            for (int unsigned y = 0; y < h; y++)
               for (int unsigned x = 0; x < w; x++) store_cell(x, y, ChSpace, attr_q);
         end
      endcase
      v.cur_row = cur_r[RowW-1:0];
      v.cur_col = cur_c[ColW-1:0];
      return v;
   endfunction

   function automatic int pick_gap(bit steady);
      int p;
      if (steady) return 0;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // response side stalls
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else begin
         if ($urandom_range(0, 299) == 0) rsp_steady <= ~rsp_steady;
         if (rsp_steady) rsp_bus.ready <= 1'b1;
         else if ($urandom_range(0, 99) < 4) rsp_bus.ready <= 1'b0;
         else if ($urandom_range(0, 99) < 60) rsp_bus.ready <= 1'b1;
      end
   end

   // check each response transfer against the oldest pending view
   always @(posedge clock) begin
      console_view_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_views.size() == 0) report_mismatch("unexpected response", 1, 0);
         else begin
            want = pending_views.pop_front();
            if (rsp_bus.cursor_row_now !== want.cur_row)
               report_mismatch("cursor_row_now", rsp_bus.cursor_row_now, want.cur_row);
            if (rsp_bus.cursor_column_now !== want.cur_col)
               report_mismatch("cursor_column_now", rsp_bus.cursor_column_now, want.cur_col);
            if (rsp_bus.cell_char !== want.ch)
               report_mismatch("cell_char", rsp_bus.cell_char, want.ch);
            if (rsp_bus.cell_attribute !== want.attr)
               report_mismatch("cell_attribute", rsp_bus.cell_attribute, want.attr);
         end
      end
   end

   // one request transfer; valid stays high when the next item follows at once
   task automatic send_item(kind_type kind, logic [7:0] ch, logic [RowW-1:0] row,
                            logic [ColW-1:0] col);
      int gap;
      if ($urandom_range(0, 149) == 0) req_steady = ~req_steady;
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.char_code <= ch;
      req_bus.row       <= row;
      req_bus.column    <= col;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_views.push_back(console_step(kind, ch, row, col));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (addr)
         AddrAttr: attr_q = data[7:0];
         AddrCols: cols_q = data[ColW-1:0];
         AddrRows: rows_q = data[RowW-1:0];
         default: ;
      endcase
   endtask

   task automatic set_screen(logic [7:0] at, logic [ColW-1:0] cols, logic [RowW-1:0] rows);
      wait_idle();
      csr_write(AddrAttr, {24'd0, at});
      csr_write(AddrCols, {{(32-ColW){1'b0}}, cols});
      csr_write(AddrRows, {{(32-RowW){1'b0}}, rows});
   endtask

   function automatic logic [7:0] random_char();
      logic [7:0] ctl [5] = '{ChNewline, ChReturn, ChBackspace, ChTab, ChEscape};
      if ($urandom_range(0, 99) < 35) return ctl[$urandom_range(0, 4)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_item(int clear_pct);
      int p;
      logic [RowW-1:0] r;
      logic [ColW-1:0] c;
      p = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) begin
         r = RowW'($urandom_range(0, height_now() - 1));
         c = ColW'($urandom_range(0, width_now() - 1));
      end else begin
         r = RowW'($urandom);
         c = ColW'($urandom);
      end
      if (p < clear_pct) send_item(KIND_CLEAR, 8'($urandom), r, c);
      else if (p < 58) send_item(KIND_PUT, random_char(), r, c);
      else if (p < 80) send_item(KIND_READ, 8'($urandom), r, c);
      else send_item(KIND_SETC, 8'($urandom), r, c);
   endtask

   // extremes, every kind and every control character at the reset size
   task automatic test_directed();
      send_item(KIND_PUT, "A", 0, 0);
      send_item(KIND_PUT, 8'h00, 0, 0);
      send_item(KIND_PUT, 8'hFF, 0, 0);
      send_item(KIND_PUT, ChBackspace, 0, 0);
      send_item(KIND_PUT, ChTab, 0, 0);
      send_item(KIND_PUT, ChEscape, 0, 0);
      send_item(KIND_PUT, ChNewline, 0, 0);
      send_item(KIND_PUT, ChBackspace, 0, 0);
      send_item(KIND_PUT, ChReturn, 0, 0);
      send_item(KIND_SETC, 0, 0, 0);
      send_item(KIND_PUT, ChBackspace, 0, 0);
      send_item(KIND_READ, 0, 0, 0);
      send_item(KIND_READ, 0, 0, 2);
      send_item(KIND_READ, 0, 5'h1F, 7'h7F);
      send_item(KIND_SETC, 8'hFF, 5'h1F, 7'h7F);
      send_item(KIND_PUT, "z", 0, 0);
      send_item(KIND_READ, 0, 23, 0);
      send_item(KIND_SETC, 0, 24, 76);
      send_item(KIND_PUT, ChTab, 0, 0);
      send_item(KIND_SETC, 0, 24, 0);
      send_item(KIND_PUT, ChNewline, 0, 0);
      send_item(KIND_CLEAR, 8'hFF, 5'h1F, 7'h7F);
      send_item(KIND_READ, 0, 10, 10);
   endtask

   // size extremes, including out-of-range sizes and a shrink under the cursor
   task automatic test_size_extremes();
      set_screen(8'hFF, 0, 0);
      repeat (30) random_item(5);
      set_screen(8'h00, 7'h7F, 5'h1F);
      repeat (30) random_item(3);
      set_screen(8'hA5, 1, 25);
      repeat (30) random_item(5);
      set_screen(8'h5A, 80, 1);
      repeat (30) random_item(5);
      set_screen(8'h3C, 3, 2);
      repeat (30) random_item(5);
   endtask

   // bulk random traffic at small sizes, settings changed between phases
   task automatic test_random_small();
      repeat (10) begin
         set_screen(8'($urandom), ColW'($urandom_range(1, 12)), RowW'($urandom_range(1, 6)));
         repeat (55) random_item(6);
      end
   endtask

   task automatic test_random_full();
      set_screen(8'($urandom), 80, 25);
      repeat (130) random_item(2);
   endtask

   initial begin
      for (int i = 0; i < CellCount; i++) shadow_cells[i] = ResetCell;
      cur_r  = 0;
      cur_c  = 0;
      attr_q = AttrReset;
      cols_q = ColsReset;
      rows_q = RowsReset;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= KIND_PUT;
      req_bus.char_code <= '0;
      req_bus.row       <= '0;
      req_bus.column    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_size_extremes();
      test_random_small();
      test_random_full();
      wait_idle();
      repeat (DrainWait) @(posedge clock);
      if (err_count == 0 && pending_views.size() == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
